@@ design/golden_section_minimum_search_top_assert.svh @@
// Assertion macros shared by the golden-section search RTL.
// Each macro expands to one labeled concurrent assertion, clocked on the
// rising edge and disabled while the synchronous active-low reset is held.
`ifndef GOLDEN_SECTION_MINIMUM_SEARCH_TOP_ASSERT_SVH
`define GOLDEN_SECTION_MINIMUM_SEARCH_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GSS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GSS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/gss_pkg.sv @@
`default_nettype none

package gss_pkg;

    // Point and value width used when the top level is not overridden.
    localparam int POINT_WIDTH_DEF = 32;

    // Configuration port.
    localparam int REL_TOL_W   = 16;
    localparam int ABS_TOL_W   = 31;
    localparam int CFG_DATA_W  = 31;
    localparam int CFG_INDEX_W = 1;

    localparam logic [REL_TOL_W-1:0] REL_TOL_RESET = 16'd66;
    localparam logic [ABS_TOL_W-1:0] ABS_TOL_RESET = 31'd1;

    // Shared multiplier operand width and the golden-ratio weights in Q0.32.
    // The two weights add up to exactly one.
    localparam int              MUL_W  = 32;
    localparam logic [MUL_W-1:0] COEF_R = 32'd2654435775;
    localparam logic [MUL_W-1:0] COEF_C = 32'd1640531521;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_REL_TOL = 1'b0,
        CFG_ABS_TOL = 1'b1
    } t_cfg_index;

    typedef enum logic {
        CMD_START = 1'b0,
        CMD_VALUE = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        STAT_PROBE   = 2'd0,
        STAT_DONE    = 2'd1,
        STAT_IGNORED = 2'd2
    } t_status;

    // What the output register is loaded with.
    typedef enum logic [1:0] {
        OUT_PROBE_L = 2'd0,
        OUT_PROBE_R = 2'd1,
        OUT_DONE    = 2'd2,
        OUT_IGNORED = 2'd3
    } t_out_kind;

    // One pass of the shared multiplier: low or high 32-bit chunk of the
    // kept point (weight R) or of the outer point (weight C).
    typedef enum logic [1:0] {
        MUL_P_LO = 2'd0,
        MUL_P_HI = 2'd1,
        MUL_Q_LO = 2'd2,
        MUL_Q_HI = 2'd3
    } t_mul_step;

    typedef struct packed {
        logic      load_start;
        logic      load_vl;
        logic      load_vr;
        logic      do_span;
        logic      set_dir;
        logic      dir_right;
        logic      move;
        logic      mul_issue;
        t_mul_step mul_step;
        logic      write_mix;
        logic      do_mag;
        logic      do_thr;
        logic      out_load;
        t_out_kind out_kind;
    } t_dp_cmd;

    typedef struct packed {
        logic span_right;
        logic keep_going;
        logic right_lower;
    } t_dp_stat;

endpackage

`default_nettype wire

@@ design/gss_in_if.sv @@
`default_nettype none

interface gss_in_if import gss_pkg::*; #(
    parameter int POINT_WIDTH = POINT_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic                          cmd;
    logic signed [POINT_WIDTH-1:0] point_a;
    logic signed [POINT_WIDTH-1:0] point_b;
    logic signed [POINT_WIDTH-1:0] point_c;
    logic signed [POINT_WIDTH-1:0] func_value;

    modport source (
        output valid, cmd, point_a, point_b, point_c, func_value,
        input  ready
    );

    modport sink (
        input  valid, cmd, point_a, point_b, point_c, func_value,
        output ready
    );
endinterface

`default_nettype wire

@@ design/gss_out_if.sv @@
`default_nettype none

interface gss_out_if import gss_pkg::*; #(
    parameter int POINT_WIDTH = POINT_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic [1:0]                    status;
    logic signed [POINT_WIDTH-1:0] probe_x;
    logic signed [POINT_WIDTH-1:0] best_x;
    logic signed [POINT_WIDTH-1:0] best_value;

    modport source (
        output valid, status, probe_x, best_x, best_value,
        input  ready
    );

    modport sink (
        input  valid, status, probe_x, best_x, best_value,
        output ready
    );
endinterface

`default_nettype wire

@@ design/gss_controller.sv @@
`default_nettype none

`include "golden_section_minimum_search_top_assert.svh"

module gss_controller import gss_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_vld,
    input  logic     i_in_cmd,
    output logic     o_in_rdy,
    output logic     o_out_vld,
    input  logic     i_out_rdy,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_ctl
);

    typedef enum logic [9:0] {
        ST_WAIT   = 10'b00_0000_0001,
        ST_SPAN   = 10'b00_0000_0010,
        ST_ORIENT = 10'b00_0000_0100,
        ST_MAG    = 10'b00_0000_1000,
        ST_THR    = 10'b00_0001_0000,
        ST_DECIDE = 10'b00_0010_0000,
        ST_MUL    = 10'b00_0100_0000,
        ST_DRAIN  = 10'b00_1000_0000,
        ST_SUM    = 10'b01_0000_0000,
        ST_EMIT   = 10'b10_0000_0000
    } t_state;

    // Search phase: which function value the block is waiting for.
    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_FIRST  = 2'd1,
        PH_SECOND = 2'd2,
        PH_LOOP   = 2'd3
    } t_phase;

    t_state    r_state, n_state;
    t_phase    r_phase, n_phase;
    t_out_kind r_kind,  n_kind;
    logic [1:0] r_cnt,  n_cnt;
    logic      r_out_vld, n_out_vld;
    logic      in_acc;

    assign o_in_rdy  = (r_state == ST_WAIT);
    assign o_out_vld = r_out_vld;
    assign in_acc    = i_in_vld && (r_state == ST_WAIT);

    always_comb begin
        n_state   = r_state;
        n_phase   = r_phase;
        n_kind    = r_kind;
        n_cnt     = r_cnt;
        n_out_vld = r_out_vld && !i_out_rdy;
        o_ctl     = '0;

        case (r_state)
            ST_WAIT: begin
                if (in_acc) begin
                    if (i_in_cmd == CMD_START) begin
                        o_ctl.load_start = 1'b1;
                        n_phase = PH_FIRST;
                        n_kind  = OUT_PROBE_L;
                        n_state = ST_SPAN;
                    end else begin
                        case (r_phase)
                            PH_FIRST: begin
                                o_ctl.load_vl = 1'b1;
                                n_phase = PH_SECOND;
                                n_kind  = OUT_PROBE_R;
                                n_state = ST_EMIT;
                            end
                            PH_SECOND: begin
                                o_ctl.load_vr = 1'b1;
                                n_state = ST_MAG;
                            end
                            PH_LOOP: begin
                                o_ctl.load_vl = 1'b1;
                                n_state = ST_MAG;
                            end
                            default: begin
                                n_kind  = OUT_IGNORED;
                                n_state = ST_EMIT;
                            end
                        endcase
                    end
                end
            end
            ST_SPAN: begin
                o_ctl.do_span = 1'b1;
                n_state = ST_ORIENT;
            end
            ST_ORIENT: begin
                o_ctl.set_dir   = 1'b1;
                o_ctl.dir_right = i_stat.span_right;
                n_cnt   = '0;
                n_state = ST_MUL;
            end
            ST_MAG: begin
                o_ctl.do_mag = 1'b1;
                n_state = ST_THR;
            end
            ST_THR: begin
                o_ctl.do_thr = 1'b1;
                n_state = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (i_stat.keep_going) begin
                    o_ctl.move      = 1'b1;
                    o_ctl.set_dir   = 1'b1;
                    o_ctl.dir_right = i_stat.right_lower;
                    n_phase = i_stat.right_lower ? PH_SECOND : PH_LOOP;
                    n_kind  = i_stat.right_lower ? OUT_PROBE_R : OUT_PROBE_L;
                    n_cnt   = '0;
                    n_state = ST_MUL;
                end else begin
                    n_phase = PH_IDLE;
                    n_kind  = OUT_DONE;
                    n_state = ST_EMIT;
                end
            end
            ST_MUL: begin
                o_ctl.mul_issue = 1'b1;
                o_ctl.mul_step  = t_mul_step'(r_cnt);
                n_cnt = r_cnt + 2'd1;
                if (r_cnt == 2'd3) begin
                    n_cnt   = '0;
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_cnt = r_cnt + 2'd1;
                if (r_cnt == 2'd1) begin
                    n_state = ST_SUM;
                end
            end
            ST_SUM: begin
                o_ctl.write_mix = 1'b1;
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (!r_out_vld || i_out_rdy) begin
                    o_ctl.out_load = 1'b1;
                    o_ctl.out_kind = r_kind;
                    n_out_vld = 1'b1;
                    n_state   = ST_WAIT;
                end
            end
            default: begin
                n_state = ST_WAIT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_WAIT;
            r_phase   <= PH_IDLE;
            r_kind    <= OUT_PROBE_L;
            r_cnt     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_phase   <= n_phase;
            r_kind    <= n_kind;
            r_cnt     <= n_cnt;
            r_out_vld <= n_out_vld;
        end
    end

    `GSS_ASSERT_SAME(a_no_overwrite, i_clk, i_rst_n, o_ctl.out_load, !r_out_vld || i_out_rdy, "result overwritten before it was taken")
    `GSS_ASSERT_NEXT(a_start_seq, i_clk, i_rst_n, in_acc && i_in_cmd == CMD_START, r_state == ST_SPAN && r_phase == PH_FIRST, "start request did not begin a search")
    `GSS_ASSERT_NEXT(a_idle_value, i_clk, i_rst_n, in_acc && i_in_cmd == CMD_VALUE && r_phase == PH_IDLE, r_state == ST_EMIT && r_kind == OUT_IGNORED, "idle value not flagged")
    `GSS_ASSERT_SAME(a_mul_busy, i_clk, i_rst_n, r_state == ST_MUL, r_phase != PH_IDLE, "multiplier running without a search")
    `GSS_ASSERT_SAME(a_done_idle, i_clk, i_rst_n, r_state == ST_EMIT && r_kind == OUT_DONE, r_phase == PH_IDLE, "finished search left a phase open")

endmodule

`default_nettype wire

@@ design/gss_datapath.sv @@
`default_nettype none

module gss_datapath import gss_pkg::*; #(
    parameter int POINT_WIDTH = POINT_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [CFG_INDEX_W-1:0]        i_cfg_index,
    input  logic [CFG_DATA_W-1:0]         i_cfg_data,
    input  t_dp_cmd                       i_ctl,
    input  logic signed [POINT_WIDTH-1:0] i_point_a,
    input  logic signed [POINT_WIDTH-1:0] i_point_b,
    input  logic signed [POINT_WIDTH-1:0] i_point_c,
    input  logic signed [POINT_WIDTH-1:0] i_func_value,
    output t_dp_stat                      o_sts,
    output logic [1:0]                    o_status,
    output logic signed [POINT_WIDTH-1:0] o_probe_x,
    output logic signed [POINT_WIDTH-1:0] o_best_x,
    output logic signed [POINT_WIDTH-1:0] o_best_value
);

    localparam int W      = POINT_WIDTH;
    localparam int EXT_W  = (W > MUL_W) ? W : MUL_W + 1;
    localparam int SUM_W  = (W < 64) ? W + 1 : 64;
    localparam int CMP_W  = (SUM_W > ABS_TOL_W) ? SUM_W : ABS_TOL_W;
    localparam int PROD_W = 2 * MUL_W;
    localparam int THP_W  = SUM_W + REL_TOL_W;

    localparam logic [W:0]          SUM_MAX    = {(W + 1){1'b1}} >> (W + 1 - SUM_W);
    localparam logic [PROD_W:0]     ROUND_HALF = (PROD_W + 1)'(1) << (MUL_W - 1);
    localparam logic signed [W+1:0] SAT_HI     = {3'b000, {(W - 1){1'b1}}};
    localparam logic signed [W+1:0] SAT_LO     = {3'b111, {(W - 1){1'b0}}};

    function automatic logic [W-1:0] f_mag(input logic signed [W-1:0] v);
        f_mag = v[W-1] ? W'(-v) : W'(v);
    endfunction

    function automatic logic [W-1:0] f_absdiff(input logic signed [W-1:0] a,
                                               input logic signed [W-1:0] b);
        f_absdiff = (a >= b) ? W'(a - b) : W'(b - a);
    endfunction

    // Configuration and bracket state.
    logic [REL_TOL_W-1:0] r_rel_tol;
    logic [ABS_TOL_W-1:0] r_abs_tol;
    logic signed [W-1:0]  r_x0, r_x1, r_x2, r_x3;
    logic signed [W-1:0]  r_vl, r_vr;
    logic                 r_dir_right;

    // Stop test and orientation.
    logic [W-1:0]     r_span_l, r_span_r;
    logic [SUM_W-1:0] r_msum, r_thr;
    logic [W-1:0]     r_width;

    // Multiplier pipeline.
    logic             r_a_vld, r_b_vld;
    t_mul_step        r_a_step, r_b_step;
    logic [MUL_W-1:0] r_op, r_k;
    logic [PROD_W-1:0] r_prod;
    logic [EXT_W-1:0] r_acc_p, r_acc_q;

    // Output register.
    t_status         r_status;
    logic signed [W-1:0] r_probe, r_best_x, r_best_value;

    logic signed [W-1:0] mix_p, mix_q, sel_pt;
    logic [W-1:0]        sel_mag;
    logic [EXT_W-1:0]    sel_ext;
    logic                step_hi, step_q;
    logic [MUL_W-1:0]    chunk, coef;
    logic [PROD_W:0]     rnd_sum;
    logic [EXT_W-1:0]    lo_part;
    logic [W-1:0]        rp, rq;
    logic signed [W:0]   term_p, term_q;
    logic signed [W+1:0] mix_sum;
    logic signed [W-1:0] mix_res;
    logic [W:0]          mag_sum;
    logic [SUM_W-1:0]    msum_next;
    logic [THP_W-1:0]    thr_prod;

    // The kept point P and the outer point Q of the next golden split.
    assign mix_p = r_dir_right ? r_x1 : r_x2;
    assign mix_q = r_dir_right ? r_x3 : r_x0;

    assign step_hi = (i_ctl.mul_step == MUL_P_HI) || (i_ctl.mul_step == MUL_Q_HI);
    assign step_q  = (i_ctl.mul_step == MUL_Q_LO) || (i_ctl.mul_step == MUL_Q_HI);
    assign sel_pt  = step_q ? mix_q : mix_p;
    assign sel_mag = f_mag(sel_pt);
    assign sel_ext = EXT_W'(sel_mag);
    assign chunk   = step_hi ? MUL_W'(sel_ext[EXT_W-1:MUL_W]) : sel_ext[MUL_W-1:0];
    assign coef    = step_q ? COEF_C : COEF_R;

    // Low chunk products round half up to the point grid.
    assign rnd_sum = {1'b0, r_prod} + ROUND_HALF;
    assign lo_part = EXT_W'(rnd_sum[PROD_W:MUL_W]);

    // Apply the signs, add and saturate to the point range.
    assign rp      = r_acc_p[W-1:0];
    assign rq      = r_acc_q[W-1:0];
    assign term_p  = mix_p[W-1] ? -$signed({1'b0, rp}) : $signed({1'b0, rp});
    assign term_q  = mix_q[W-1] ? -$signed({1'b0, rq}) : $signed({1'b0, rq});
    assign mix_sum = (W + 2)'(term_p) + (W + 2)'(term_q);
    assign mix_res = (mix_sum > SAT_HI) ? W'(SAT_HI) :
                     (mix_sum < SAT_LO) ? W'(SAT_LO) : W'(mix_sum);

    assign mag_sum   = (W + 1)'(f_mag(r_x1)) + (W + 1)'(f_mag(r_x2));
    assign msum_next = (mag_sum > SUM_MAX) ? SUM_MAX[SUM_W-1:0] : mag_sum[SUM_W-1:0];
    assign thr_prod  = THP_W'(r_msum) * THP_W'(r_rel_tol);

    assign o_sts.span_right  = (r_span_r > r_span_l);
    assign o_sts.keep_going  = (CMP_W'(r_width) > CMP_W'(r_thr)) &&
                               (CMP_W'(r_width) > CMP_W'(r_abs_tol));
    assign o_sts.right_lower = (r_vr < r_vl);

    assign o_status     = r_status;
    assign o_probe_x    = r_probe;
    assign o_best_x     = r_best_x;
    assign o_best_value = r_best_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rel_tol <= REL_TOL_RESET;
            r_abs_tol <= ABS_TOL_RESET;
            r_a_vld   <= 1'b0;
            r_b_vld   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_index'(i_cfg_index))
                    CFG_REL_TOL: r_rel_tol <= i_cfg_data[REL_TOL_W-1:0];
                    CFG_ABS_TOL: r_abs_tol <= i_cfg_data[ABS_TOL_W-1:0];
                    default: ;
                endcase
            end
            r_a_vld <= i_ctl.mul_issue;
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_start) begin
            r_x0 <= i_point_a;
            r_x1 <= i_point_b;
            r_x2 <= i_point_b;
            r_x3 <= i_point_c;
        end
        if (i_ctl.load_vl) begin
            r_vl <= i_func_value;
        end
        if (i_ctl.load_vr) begin
            r_vr <= i_func_value;
        end
        if (i_ctl.do_span) begin
            r_span_l <= f_absdiff(r_x1, r_x0);
            r_span_r <= f_absdiff(r_x3, r_x1);
        end
        if (i_ctl.set_dir) begin
            r_dir_right <= i_ctl.dir_right;
        end
        if (i_ctl.move) begin
            if (i_ctl.dir_right) begin
                r_x0 <= r_x1;
                r_x1 <= r_x2;
                r_vl <= r_vr;
            end else begin
                r_x3 <= r_x2;
                r_x2 <= r_x1;
                r_vr <= r_vl;
            end
        end
        if (i_ctl.write_mix) begin
            if (r_dir_right) begin
                r_x2 <= mix_res;
            end else begin
                r_x1 <= mix_res;
            end
        end
        if (i_ctl.do_mag) begin
            r_msum  <= msum_next;
            r_width <= f_absdiff(r_x3, r_x0);
        end
        if (i_ctl.do_thr) begin
            r_thr <= thr_prod[THP_W-1:REL_TOL_W];
        end

        if (i_ctl.mul_issue) begin
            r_op     <= chunk;
            r_k      <= coef;
            r_a_step <= i_ctl.mul_step;
        end
        r_prod   <= r_op * r_k;
        r_b_step <= r_a_step;
        if (r_b_vld) begin
            case (r_b_step)
                MUL_P_LO: r_acc_p <= lo_part;
                MUL_P_HI: r_acc_p <= r_acc_p + r_prod[EXT_W-1:0];
                MUL_Q_LO: r_acc_q <= lo_part;
                MUL_Q_HI: r_acc_q <= r_acc_q + r_prod[EXT_W-1:0];
                default: ;
            endcase
        end

        if (i_ctl.out_load) begin
            case (i_ctl.out_kind)
                OUT_PROBE_L: begin
                    r_status     <= STAT_PROBE;
                    r_probe      <= r_x1;
                    r_best_x     <= '0;
                    r_best_value <= '0;
                end
                OUT_PROBE_R: begin
                    r_status     <= STAT_PROBE;
                    r_probe      <= r_x2;
                    r_best_x     <= '0;
                    r_best_value <= '0;
                end
                OUT_DONE: begin
                    r_status <= STAT_DONE;
                    r_probe  <= '0;
                    if (r_vl < r_vr) begin
                        r_best_x     <= r_x1;
                        r_best_value <= r_vl;
                    end else begin
                        r_best_x     <= r_x2;
                        r_best_value <= r_vr;
                    end
                end
                default: begin
                    r_status     <= STAT_IGNORED;
                    r_probe      <= '0;
                    r_best_x     <= '0;
                    r_best_value <= '0;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

@@ design/golden_section_minimum_search_top.sv @@
`default_nettype none

// Golden-section minimum search over a function that is evaluated outside the
// block. A start request (cmd 0) carries a bracket a, b, c; the block answers
// with the first abscissa to evaluate (status 0, probe_x). Every value request
// (cmd 1) returns the function value at the last probe, and the block answers
// either with the next probe or, once the outer bracket width is no longer
// above both the relative and the absolute tolerance, with status 1 and the
// best abscissa and value. A value request while no search runs gets status 2
// and leaves the state alone, and a start request always restarts the search.
// Each request produces exactly one response. Points and values are signed
// two's complement of POINT_WIDTH bits; new points are the 0.618/0.382 mix of
// two points with Q0.32 weights, each product rounded half away from zero and
// the sum saturated. The block takes one request at a time. A first value or
// an idle value goes straight to the response. A start request first passes
// the span and orientation states, and a value inside the search loop first
// passes the stop test (magnitude, threshold and decide states). A value that
// ends the search then goes to the response; any other start or loop value
// runs the new point through the single shared 32 x 32 multiplier, which
// makes four passes (low and high chunk of each of the two weighted points)
// through a three-stage pipeline, followed by the signed sum. The response
// sits in an output register, so the block returns to accepting requests
// while that response waits to be taken. Configuration register 0 is the
// relative tolerance (unsigned Q0.16, reset 66) and register 1 the absolute
// tolerance (reset 1); write them only while the block is idle.
module golden_section_minimum_search_top import gss_pkg::*; #(
    parameter int POINT_WIDTH = POINT_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    gss_in_if.sink                 i_req,
    gss_out_if.source              o_rsp,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    // Command and status bundles between the sequencer and the datapath.
    t_dp_cmd  ctl;
    t_dp_stat sts;
    logic     in_rdy;
    logic     out_vld;

    gss_controller u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_vld  (i_req.valid),
        .i_in_cmd  (i_req.cmd),
        .o_in_rdy  (in_rdy),
        .o_out_vld (out_vld),
        .i_out_rdy (o_rsp.ready),
        .i_stat    (sts),
        .o_ctl     (ctl)
    );

    // The datapath holds the bracket, the shared multiplier, the stop test
    // and the response register.
    gss_datapath #(
        .POINT_WIDTH (POINT_WIDTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_ctl        (ctl),
        .i_point_a    (i_req.point_a),
        .i_point_b    (i_req.point_b),
        .i_point_c    (i_req.point_c),
        .i_func_value (i_req.func_value),
        .o_sts        (sts),
        .o_status     (o_rsp.status),
        .o_probe_x    (o_rsp.probe_x),
        .o_best_x     (o_rsp.best_x),
        .o_best_value (o_rsp.best_value)
    );

    assign i_req.ready = in_rdy;
    assign o_rsp.valid = out_vld;

endmodule

`default_nettype wire
